// ----- design/tds_pkg.sv -----
// Shared types, constants and index helpers for the term deque with search.
package tds_pkg;

  // Storage geometry.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [3:0]       pos_t;
  typedef logic [4:0]       rmv_t;

  // Operation codes.
  localparam logic [2:0] FN_PUSH_BACK  = 3'd0;
  localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
  localparam logic [2:0] FN_POP_BACK   = 3'd2;
  localparam logic [2:0] FN_POP_FRONT  = 3'd3;
  localparam logic [2:0] FN_SEARCH     = 3'd4;
  localparam logic [2:0] FN_REMOVE_ALL = 3'd5;
  localparam logic [2:0] FN_LOOKUP     = 3'd6;

  // One stored term.
  typedef struct packed {
    logic signed [31:0] coef;
    logic [15:0]        degree;
  } term_t;

  // Input item.
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] coef_in;
    logic [15:0]        degree_in;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] coef_out;
    logic [15:0]        degree_out;
    pos_t               position;
    logic               found;
    rmv_t               removed_count;
    logic               empty_error;
    logic               full_error;
  } out_t;

  // Ring position of the entry at a given offset from the head.
  function automatic idx_t slot(input idx_t head, input cnt_t off);
    sum_t sum;
    sum = sum_t'(head) + sum_t'(off);
    if (sum >= sum_t'(DEPTH)) begin
      sum = sum - sum_t'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- design/term_deque_with_search_core.sv -----
// Top level of the term deque: control sequencer, ring pointers and result register.
//
// Usage: a bounded double-ended queue of polynomial terms (coefficient, degree)
// held in a single RAM organized as a ring of tds_pkg::DEPTH entries.
// Input channel in_valid/in_stall/in_data carries one operation per transfer;
// every input transfer produces exactly one result transfer on
// out_valid/out_stall/out_data, in order.
// Pushes and unused codes go straight to the result step; pops first wait
// for one RAM read; search, remove all and degree lookup walk the entries,
// reading one entry per cycle through the single RAM read port.
// A new input transfer is taken as soon as the previous result has moved
// into the output register, so a waiting result does not block the next item.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; RAM contents are not cleared and are never read before written.
// When the receiver stalls, the result holds steady in the output register;
// a second finished result waits internally and in_stall stays high.
module term_deque_with_search_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tds_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tds_pkg::out_t  out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam tds_pkg::cnt_t CNT_FULL = tds_pkg::cnt_t'(tds_pkg::DEPTH);
  localparam tds_pkg::idx_t IDX_LAST = tds_pkg::idx_t'(tds_pkg::DEPTH - 1);
  localparam tds_pkg::cnt_t CNT_ONE  = tds_pkg::cnt_t'(1);

  logic [1:0]         state_r, state_nxt;
  tds_pkg::cnt_t      cnt_r, cnt_nxt;
  tds_pkg::idx_t      head_r, head_nxt;
  logic               out_valid_r, out_valid_nxt;
  tds_pkg::out_t      out_data_r, out_data_nxt;
  tds_pkg::out_t      res_r, res_nxt;
  logic [2:0]         func_r, func_nxt;
  logic signed [31:0] key_coef_r, key_coef_nxt;
  logic [15:0]        key_deg_r, key_deg_nxt;
  tds_pkg::cnt_t      rd_i_r, rd_i_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  tds_pkg::cnt_t      cmp_i_r, cmp_i_nxt;
  tds_pkg::cnt_t      kept_r, kept_nxt;
  tds_pkg::cnt_t      removed_r, removed_nxt;

  logic               ram_wr_en;
  tds_pkg::idx_t      ram_wr_addr;
  tds_pkg::term_t     ram_wr_data;
  logic               ram_rd_en;
  tds_pkg::idx_t      ram_rd_addr;
  tds_pkg::term_t     ram_rd_data;
  logic               hit;
  logic               stop;

  // Term storage.
  tds_ram #(
    .WIDTH ($bits(tds_pkg::term_t)),
    .DEPTH (tds_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Compare the entry returned by the RAM against the search key.
  always_comb begin
    if (func_r == tds_pkg::FN_LOOKUP) begin
      hit = (ram_rd_data.degree == key_deg_r);
    end else begin
      hit = (ram_rd_data.degree == key_deg_r) && (ram_rd_data.coef == key_coef_r);
    end
  end

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    func_nxt      = func_r;
    key_coef_nxt  = key_coef_r;
    key_deg_nxt   = key_deg_r;
    rd_i_nxt      = rd_i_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_i_nxt     = cmp_i_r;
    kept_nxt      = kept_r;
    removed_nxt   = removed_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = '0;
    ram_wr_data   = '0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    stop          = 1'b0;

    // The output register empties on a result transfer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt     = in_data.func;
          key_coef_nxt = in_data.coef_in;
          key_deg_nxt  = in_data.degree_in;
          res_nxt      = '0;
          rd_i_nxt     = '0;
          cmp_v_nxt    = 1'b0;
          kept_nxt     = '0;
          removed_nxt  = '0;
          state_nxt    = S_DONE;
          unique case (in_data.func)
            tds_pkg::FN_PUSH_BACK, tds_pkg::FN_PUSH_FRONT: begin
              if (cnt_r == CNT_FULL) begin
                res_nxt.full_error = 1'b1;
              end else begin
                ram_wr_en          = 1'b1;
                ram_wr_data.coef   = in_data.coef_in;
                ram_wr_data.degree = in_data.degree_in;
                if (in_data.func == tds_pkg::FN_PUSH_BACK) begin
                  ram_wr_addr = tds_pkg::slot(head_r, cnt_r);
                end else begin
                  head_nxt    = (head_r == '0) ? IDX_LAST : head_r - tds_pkg::idx_t'(1);
                  ram_wr_addr = head_nxt;
                end
                cnt_nxt = cnt_r + CNT_ONE;
              end
            end
            tds_pkg::FN_POP_BACK, tds_pkg::FN_POP_FRONT: begin
              if (cnt_r == '0) begin
                res_nxt.empty_error = 1'b1;
              end else begin
                ram_rd_en = 1'b1;
                if (in_data.func == tds_pkg::FN_POP_BACK) begin
                  ram_rd_addr = tds_pkg::slot(head_r, cnt_r - CNT_ONE);
                end else begin
                  ram_rd_addr = head_r;
                  head_nxt    = tds_pkg::slot(head_r, CNT_ONE);
                end
                cnt_nxt   = cnt_r - CNT_ONE;
                state_nxt = S_POP;
              end
            end
            tds_pkg::FN_SEARCH, tds_pkg::FN_REMOVE_ALL, tds_pkg::FN_LOOKUP: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_POP: begin
        res_nxt.coef_out   = ram_rd_data.coef;
        res_nxt.degree_out = ram_rd_data.degree;
        state_nxt          = S_DONE;
      end

      S_SCAN: begin
        // Evaluate the entry read in the previous cycle.
        if (cmp_v_r) begin
          if (func_r == tds_pkg::FN_REMOVE_ALL) begin
            if (hit) begin
              removed_nxt = removed_r + CNT_ONE;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = tds_pkg::slot(head_r, kept_r);
              ram_wr_data = ram_rd_data;
              kept_nxt    = kept_r + CNT_ONE;
            end
          end else if (hit) begin
            stop          = 1'b1;
            res_nxt.found = 1'b1;
            if (func_r == tds_pkg::FN_SEARCH) begin
              res_nxt.position = tds_pkg::pos_t'(cmp_i_r);
            end else begin
              res_nxt.coef_out = ram_rd_data.coef;
            end
          end
        end

        // Issue the next read, or finish once nothing is in flight.
        if (stop) begin
          cmp_v_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (rd_i_r < cnt_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = tds_pkg::slot(head_r, rd_i_r);
          cmp_v_nxt   = 1'b1;
          cmp_i_nxt   = rd_i_r;
          rd_i_nxt    = rd_i_r + CNT_ONE;
        end else begin
          cmp_v_nxt = 1'b0;
          if (!cmp_v_r) begin
            state_nxt = S_DONE;
            if (func_r == tds_pkg::FN_REMOVE_ALL) begin
              cnt_nxt               = kept_r;
              res_nxt.removed_count = tds_pkg::rmv_t'(removed_r);
            end
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
    func_r     <= func_nxt;
    key_coef_r <= key_coef_nxt;
    key_deg_r  <= key_deg_nxt;
    rd_i_r     <= rd_i_nxt;
    cmp_i_r    <= cmp_i_nxt;
    kept_r     <= kept_nxt;
    removed_r  <= removed_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The entry count never exceeds the ring size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count exceeds ring size");

  // The head pointer stays inside the ring.
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= IDX_LAST)
    else $error("head pointer outside ring");

  // Compaction never writes the entry being read in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && ram_rd_en && state_r == S_SCAN) |-> (ram_wr_addr != ram_rd_addr))
    else $error("compaction write collides with walk read");

  // Survivors are never placed ahead of the entry under comparison.
  a_kept_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cmp_v_r) |-> (kept_r <= cmp_i_r))
    else $error("compaction index ran ahead of walk");

  // A result only appears after the sequencer finished an item.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown without a finished item");

endmodule

// ----- design/tds_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module tds_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the term deque with search: predicted results against DUT output.
`timescale 1ns / 1ps

module testbench;

  // Code seven is not named in the package; it must leave everything unchanged.
  localparam logic [2:0] FN_UNUSED = 3'd7;

  localparam int IDLE_PCT     = 31;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 2 * tds_pkg::DEPTH + 8;
  localparam int REPORT_LIMIT = 10;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  tds_pkg::in_t   in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  tds_pkg::out_t  out_data;

  int          send_idle_pct  = IDLE_PCT;
  int          recv_stall_pct = IDLE_PCT;
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Predicted deque contents and the results still owed by the DUT.
  tds_pkg::term_t term_mem [tds_pkg::DEPTH];
  tds_pkg::idx_t  ring_head  = '0;
  int             term_count = 0;
  tds_pkg::out_t  pending_results [$];
  tds_pkg::out_t  want;

  term_deque_with_search_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Ring position of the entry at a given offset from the front.
  function automatic tds_pkg::idx_t ring_slot(int off);
    return tds_pkg::idx_t'((int'(ring_head) + off) % tds_pkg::DEPTH);
  endfunction

  // Applies one operation to the predicted deque and returns its result.
  function automatic tds_pkg::out_t apply_term_op(tds_pkg::in_t op);
    tds_pkg::out_t  res;
    tds_pkg::term_t key;
    tds_pkg::term_t t;
    int             kept;
    int             i;
    res        = '0;
    key.coef   = op.coef_in;
    key.degree = op.degree_in;
    case (op.func)
      tds_pkg::FN_PUSH_BACK, tds_pkg::FN_PUSH_FRONT: begin
        if (term_count >= tds_pkg::DEPTH) begin
          res.full_error = 1'b1;
        end else begin
          if (op.func == tds_pkg::FN_PUSH_BACK) begin
            term_mem[ring_slot(term_count)] = key;
          end else begin
            ring_head = ring_slot(tds_pkg::DEPTH - 1);
            term_mem[ring_head] = key;
          end
          term_count++;
        end
      end
      tds_pkg::FN_POP_BACK, tds_pkg::FN_POP_FRONT: begin
        if (term_count == 0) begin
          res.empty_error = 1'b1;
        end else begin
          if (op.func == tds_pkg::FN_POP_BACK) begin
            t = term_mem[ring_slot(term_count - 1)];
          end else begin
            t = term_mem[ring_head];
            ring_head = ring_slot(1);
          end
          res.coef_out   = t.coef;
          res.degree_out = t.degree;
          term_count--;
        end
      end
      tds_pkg::FN_SEARCH: begin
        for (i = 0; i < term_count; i++) begin
          if (term_mem[ring_slot(i)] == key) begin
            res.found    = 1'b1;
            res.position = tds_pkg::pos_t'(i);
            break;
          end
        end
      end
      tds_pkg::FN_REMOVE_ALL: begin
        // Survivors are compacted toward the front in their original order.
        kept = 0;
        for (i = 0; i < term_count; i++) begin
          t = term_mem[ring_slot(i)];
          if (t == key) begin
            res.removed_count = res.removed_count + 1'b1;
          end else begin
            term_mem[ring_slot(kept)] = t;
            kept++;
          end
        end
        term_count = kept;
      end
      tds_pkg::FN_LOOKUP: begin
        for (i = 0; i < term_count; i++) begin
          if (term_mem[ring_slot(i)].degree == op.degree_in) begin
            res.found    = 1'b1;
            res.coef_out = term_mem[ring_slot(i)].coef;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic string describe(tds_pkg::out_t r);
    return $sformatf("coef=%0d degree=%0d pos=%0d found=%0b removed=%0d empty=%0b full=%0b",
                     r.coef_out, r.degree_out, r.position, r.found, r.removed_count,
                     r.empty_error, r.full_error);
  endfunction

  // Offers one operation, holds it until the transfer, then records its prediction.
  task automatic send_op(logic [2:0] func, logic signed [31:0] coef, logic [15:0] degree);
    tds_pkg::in_t op;
    op.func      = func;
    op.coef_in   = coef;
    op.degree_in = degree;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_term_op(op));
  endtask

  // Holds off the sender until every predicted result has been transferred.
  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One random operation; terms are often taken from the deque so that matches happen.
  task automatic send_random_op(int push_pct);
    logic [2:0]     func;
    tds_pkg::term_t t;
    int unsigned    sel;
    sel = $urandom_range(0, 99);
    if (sel < push_pct) begin
      func = $urandom_range(0, 1) ? tds_pkg::FN_PUSH_FRONT : tds_pkg::FN_PUSH_BACK;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        func = $urandom_range(0, 1) ? tds_pkg::FN_POP_FRONT : tds_pkg::FN_POP_BACK;
      end else if (sel < 65) begin
        func = tds_pkg::FN_SEARCH;
      end else if (sel < 78) begin
        func = tds_pkg::FN_REMOVE_ALL;
      end else if (sel < 96) begin
        func = tds_pkg::FN_LOOKUP;
      end else begin
        func = FN_UNUSED;
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 40 && term_count != 0) begin
      t = term_mem[ring_slot(int'($urandom_range(0, term_count - 1)))];
    end else if (sel < 75) begin
      t.coef   = $urandom_range(0, 4) - 2;
      t.degree = 16'($urandom_range(0, 3));
    end else begin
      t.coef   = $urandom;
      t.degree = 16'($urandom_range(0, 16'hFFFF));
    end
    send_op(func, t.coef, t.degree);
  endtask

  // Every query and pop against an empty deque, plus the unused code.
  task automatic test_empty_store;
    send_op(tds_pkg::FN_POP_BACK, 0, 0);
    send_op(tds_pkg::FN_POP_FRONT, 0, 0);
    send_op(tds_pkg::FN_SEARCH, 0, 0);
    send_op(tds_pkg::FN_REMOVE_ALL, 0, 0);
    send_op(tds_pkg::FN_LOOKUP, 0, 0);
    send_op(FN_UNUSED, -1, 16'hFFFF);
  endtask

  // Fills the deque from both ends, pushes into it while full, searches it, then empties it in one removal.
  task automatic test_full_store;
    int i;
    for (i = 0; i < tds_pkg::DEPTH; i++) begin
      send_op((i % 2) ? tds_pkg::FN_PUSH_FRONT : tds_pkg::FN_PUSH_BACK, 5, 7);
    end
    send_op(tds_pkg::FN_PUSH_BACK, 9, 9);
    send_op(tds_pkg::FN_PUSH_FRONT, 9, 9);
    send_op(tds_pkg::FN_SEARCH, 5, 7);
    send_op(tds_pkg::FN_REMOVE_ALL, 5, 7);
  endtask

  // Extreme coefficients and degrees through every operation.
  task automatic test_extreme_terms;
    send_op(tds_pkg::FN_PUSH_BACK, 32'sh7FFF_FFFF, 16'hFFFF);
    send_op(tds_pkg::FN_PUSH_FRONT, 32'sh8000_0000, 16'h0000);
    send_op(tds_pkg::FN_PUSH_BACK, -1, 16'h0001);
    send_op(tds_pkg::FN_PUSH_FRONT, 0, 16'hFFFF);
    send_op(tds_pkg::FN_SEARCH, -1, 16'h0001);
    send_op(tds_pkg::FN_SEARCH, -1, 16'h0000);
    send_op(tds_pkg::FN_LOOKUP, 0, 16'hFFFF);
    send_op(tds_pkg::FN_LOOKUP, 0, 16'h0002);
    send_op(tds_pkg::FN_REMOVE_ALL, 32'sh7FFF_FFFF, 16'hFFFF);
    send_op(tds_pkg::FN_POP_FRONT, 0, 0);
    send_op(tds_pkg::FN_POP_BACK, 0, 0);
  endtask

  // Random traffic that alternates between filling and draining phases.
  task automatic test_random_traffic(int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_random_op(((i / 60) % 2 == 0) ? 70 : 25);
    end
  endtask

  // Random traffic with neither side ever idling.
  task automatic test_back_to_back(int count);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(count);
    send_idle_pct  = IDLE_PCT;
    recv_stall_pct = IDLE_PCT;
  endtask

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Each result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result: %s", describe(out_data));
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.coef_out !== want.coef_out || out_data.degree_out !== want.degree_out ||
            out_data.position !== want.position || out_data.found !== want.found ||
            out_data.removed_count !== want.removed_count ||
            out_data.empty_error !== want.empty_error ||
            out_data.full_error !== want.full_error) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("result mismatch: expected %s", describe(want));
            $display("                 actual   %s", describe(out_data));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("term_deque_with_search_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_store;
    test_full_store;
    test_extreme_terms;
    test_random_traffic(900);
    wait_for_results;
    test_back_to_back(300);
    test_random_traffic(300);
    wait_for_results;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("term_deque_with_search_core regression: pass");
    end else begin
      $display("term_deque_with_search_core regression: fail");
    end
    $finish;
  end

endmodule
